FILE: design/tvdh_pkg.sv
`default_nettype none
package tvdh_pkg;
    localparam int TABLE_SLOTS  = 65536;
    localparam int MAX_VERTICES = 32768;
    localparam int SLOT_W = $clog2(TABLE_SLOTS);
    localparam int VID_W  = $clog2(MAX_VERTICES);
    localparam int CNT_W  = VID_W + 1;
    localparam int SENT_W = CNT_W;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NONFIN  = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_MIX, S_RDSLOT, S_WAITSLOT, S_RDVERT, S_WAITVERT,
        S_CMP, S_NEXT, S_DONE
    } state_t;

    typedef struct packed {
        logic       start;
        logic [2:0] round;
    } mix_ctl_t;

    function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] k);
        rotl = (v << k) | (v >> (6'd32 - {1'b0, k}));
    endfunction
endpackage
`default_nettype wire

FILE: design/triangle_vertex_dedup_hash_core.sv
// channel  | handshake      | payload
// facet    | start / busy   | normal_*_bits, first/second/third_*_bits
// result   | done strobe    | *_id, *_is_new, triangle_kept, status, unique_count
// busy covers S_DONE for a rejected facet; for an accepted one 3 x 7 rounds of the
// shared mix unit, S_RDSLOT, S_WAITSLOT and S_CMP for a probe that meets an empty slot,
// with S_RDVERT, S_WAITVERT for one reading a stored vertex, plus S_NEXT and S_DONE
// after reset a clearing pass over all TABLE_SLOTS slots empties the slot table,
// busy is high meanwhile
// done is high for one cycle, the first with busy low; the receiver cannot stall it
`default_nettype none
module triangle_vertex_dedup_hash_core import tvdh_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] normal_x_bits,
    input  wire logic [31:0] normal_y_bits,
    input  wire logic [31:0] normal_z_bits,
    input  wire logic [31:0] first_x_bits,
    input  wire logic [31:0] first_y_bits,
    input  wire logic [31:0] first_z_bits,
    input  wire logic [31:0] second_x_bits,
    input  wire logic [31:0] second_y_bits,
    input  wire logic [31:0] second_z_bits,
    input  wire logic [31:0] third_x_bits,
    input  wire logic [31:0] third_y_bits,
    input  wire logic [31:0] third_z_bits,
    output logic             done,
    output logic [14:0]      first_id,
    output logic [14:0]      second_id,
    output logic [14:0]      third_id,
    output logic             first_is_new,
    output logic             second_is_new,
    output logic             third_is_new,
    output logic             triangle_kept,
    output logic [1:0]       status,
    output logic [15:0]      unique_count
);
    logic [SENT_W-1:0] slot_mem [TABLE_SLOTS];
    logic [95:0]       vert_mem [MAX_VERTICES];

    state_t state_reg, state_next;
    logic [SLOT_W-1:0] clr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [95:0]       v_reg [3];
    logic [1:0]        k_reg;
    logic [2:0]        round_reg;
    logic [SLOT_W-1:0] pos_reg;
    logic [SENT_W-1:0] slot_q_reg;
    logic [95:0]       vert_q_reg;
    logic [VID_W-1:0]  id_reg [3];
    logic [2:0]        new_reg;
    logic [1:0]        stat_reg;
    logic              done_reg;
    logic [31:0]       c_out;
    mix_ctl_t          mctl;

    function automatic logic fin(input logic [31:0] w);
        fin = (w[30:23] != 8'hFF);
    endfunction
    function automatic logic [31:0] cz(input logic [31:0] w);
        cz = (w == 32'h8000_0000) ? 32'd0 : w;
    endfunction

    logic all_fin, full;
    assign all_fin = fin(normal_x_bits) & fin(normal_y_bits) & fin(normal_z_bits)
        & fin(first_x_bits) & fin(first_y_bits) & fin(first_z_bits)
        & fin(second_x_bits) & fin(second_y_bits) & fin(second_z_bits)
        & fin(third_x_bits) & fin(third_y_bits) & fin(third_z_bits);
    assign full = ({1'b0, count_reg} + (CNT_W+1)'(3) > (CNT_W+1)'(MAX_VERTICES))
        || (32'(count_reg) + 32'd3 > 32'(TABLE_SLOTS));

    logic [95:0] cur_v;
    logic [95:0] mix_v;
    assign cur_v = v_reg[k_reg];
    // in S_NEXT the mix is loaded with the vertex that follows
    assign mix_v = (state_reg == S_NEXT) ? v_reg[k_reg + 2'd1] : cur_v;

    assign mctl.start = (state_reg == S_IDLE) || (state_reg == S_NEXT);
    assign mctl.round = round_reg;

    tvdh_mix u_mix (
        .clk  (clk),
        .ctl  (mctl),
        .a_in (state_reg == S_IDLE ? cz(first_x_bits) : mix_v[95:64]),
        .b_in (state_reg == S_IDLE ? cz(first_y_bits) : mix_v[63:32]),
        .c_in (state_reg == S_IDLE ? cz(first_z_bits) : mix_v[31:0]),
        .c_out(c_out)
    );

    logic go;
    assign go = start && !busy;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:    if (clr_reg == SLOT_W'(TABLE_SLOTS - 1)) state_next = S_IDLE;
            S_IDLE:     if (go) state_next = (all_fin && !full) ? S_MIX : S_DONE;
            S_MIX:      if (round_reg == 3'd6) state_next = S_RDSLOT;
            S_RDSLOT:   state_next = S_WAITSLOT;
            S_WAITSLOT: state_next = (slot_q_reg == '0) ? S_CMP : S_RDVERT;
            S_RDVERT:   state_next = S_WAITVERT;
            S_WAITVERT: state_next = S_CMP;
            S_CMP:
            begin
                if (slot_q_reg == '0 || vert_q_reg == cur_v)
                    state_next = (k_reg == 2'd2) ? S_DONE : S_NEXT;
                else
                    state_next = S_RDSLOT;
            end
            S_NEXT:     state_next = S_MIX;
            S_DONE:     state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLEAR)
            slot_mem[clr_reg] <= '0;
        else if (state_reg == S_CMP && slot_q_reg == '0)
            slot_mem[pos_reg] <= count_reg + 1'b1;
        if (state_reg == S_RDSLOT)
            slot_q_reg <= slot_mem[pos_reg];
        if (state_reg == S_CMP && slot_q_reg == '0)
            vert_mem[count_reg[VID_W-1:0]] <= cur_v;
        if (state_reg == S_RDVERT)
            vert_q_reg <= vert_mem[slot_q_reg[VID_W-1:0] - 1'b1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            count_reg <= '0;
            k_reg     <= '0;
            round_reg <= '0;
            done_reg  <= 1'b0;
            new_reg   <= '0;
            stat_reg  <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_DONE);
            if (state_reg == S_CLEAR) clr_reg <= clr_reg + 1'b1;
            if (state_reg == S_MIX) round_reg <= round_reg + 1'b1;
            else round_reg <= '0;
            if (state_reg == S_IDLE && go)
            begin
                k_reg   <= '0;
                new_reg <= '0;
                stat_reg <= !all_fin ? ST_NONFIN : (full ? ST_FULL : ST_OK);
            end
            if (state_reg == S_MIX && round_reg == 3'd6)
                pos_reg <= c_out[SLOT_W-1:0];
            if (state_reg == S_CMP)
            begin
                if (slot_q_reg == '0)
                begin
                    id_reg[k_reg]  <= count_reg[VID_W-1:0];
                    new_reg[k_reg] <= 1'b1;
                    count_reg      <= count_reg + 1'b1;
                end
                else if (vert_q_reg == cur_v)
                    id_reg[k_reg] <= slot_q_reg[VID_W-1:0] - 1'b1;
                else
                    pos_reg <= pos_reg + 1'b1;
            end
            if (state_reg == S_NEXT) k_reg <= k_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            v_reg[0] <= {cz(first_x_bits), cz(first_y_bits), cz(first_z_bits)};
            v_reg[1] <= {cz(second_x_bits), cz(second_y_bits), cz(second_z_bits)};
            v_reg[2] <= {cz(third_x_bits), cz(third_y_bits), cz(third_z_bits)};
        end
    end

    logic ok;
    assign ok = (stat_reg == ST_OK);
    assign done          = done_reg;
    assign first_id      = ok ? 15'(id_reg[0]) : '0;
    assign second_id     = ok ? 15'(id_reg[1]) : '0;
    assign third_id      = ok ? 15'(id_reg[2]) : '0;
    assign first_is_new  = ok & new_reg[0];
    assign second_is_new = ok & new_reg[1];
    assign third_is_new  = ok & new_reg[2];
    assign triangle_kept = ok && id_reg[0] != id_reg[1] && id_reg[0] != id_reg[2]
        && id_reg[1] != id_reg[2];
    assign status        = stat_reg;
    assign unique_count  = 16'(count_reg);
endmodule
`default_nettype wire

FILE: design/tvdh_mix.sv
`default_nettype none
module tvdh_mix import tvdh_pkg::*; (
    input  wire logic        clk,
    input  wire mix_ctl_t    ctl,
    input  wire logic [31:0] a_in,
    input  wire logic [31:0] b_in,
    input  wire logic [31:0] c_in,
    output logic [31:0]      c_out
);
    logic [31:0] a_reg, b_reg, c_reg;
    logic [31:0] src, dst, oth, res;
    logic [4:0]  sh;
    logic [1:0]  sel;

    // one xor-subtract step a round, seven rounds
    always_comb
    begin
        case (ctl.round)
            3'd0: begin sel = 2'd2; sh = 5'd14; end
            3'd1: begin sel = 2'd0; sh = 5'd11; end
            3'd2: begin sel = 2'd1; sh = 5'd25; end
            3'd3: begin sel = 2'd2; sh = 5'd16; end
            3'd4: begin sel = 2'd0; sh = 5'd4;  end
            3'd5: begin sel = 2'd1; sh = 5'd14; end
            default: begin sel = 2'd2; sh = 5'd24; end
        endcase
        case (sel)
            2'd0:    begin dst = a_reg; oth = c_reg; end
            2'd1:    begin dst = b_reg; oth = a_reg; end
            default: begin dst = c_reg; oth = b_reg; end
        endcase
        src = oth;
        res = (dst ^ src) - rotl(src, sh);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            a_reg <= a_in;
            b_reg <= b_in;
            c_reg <= c_in;
        end
        else
        begin
            if (sel == 2'd0) a_reg <= res;
            if (sel == 2'd1) b_reg <= res;
            if (sel == 2'd2) c_reg <= res;
        end
    end

    // c as it stands after the current round
    assign c_out = (sel == 2'd2) ? res : c_reg;
endmodule
`default_nettype wire

FILE: design/tvdh_checker.sv
`default_nettype none
module tvdh_checker import tvdh_pkg::*; (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        done,
    input wire logic [1:0]  status,
    input wire logic        triangle_kept,
    input wire logic        first_is_new,
    input wire logic [15:0] unique_count
);
    a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done held");
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> status != 2'd3) else $error("bad status");
    a_reject: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != ST_OK |-> !triangle_kept && !first_is_new)
        else $error("rejected item kept");
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        !busy && !$past(busy) |-> $stable(unique_count)) else $error("count moved");
endmodule

bind triangle_vertex_dedup_hash_core tvdh_checker u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .status(status), .triangle_kept(triangle_kept), .first_is_new(first_is_new),
    .unique_count(unique_count)
);
`default_nettype wire
